### sv/ansi_escape_filter_core_macros.svh
// assertion helpers
`ifndef ANSI_ESCAPE_FILTER_CORE_MACROS_SVH
`define ANSI_ESCAPE_FILTER_CORE_MACROS_SVH

`define AEF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define AEF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### sv/aef_pkg.sv
`timescale 1ns / 1ps
package aef_pkg;

  localparam int unsigned CodeBitsDefault = 16;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [3:0] {
    KIND_BYTE      = 4'd0,
    KIND_RESET     = 4'd1,
    KIND_BOLD      = 4'd2,
    KIND_FAINT     = 4'd3,
    KIND_UL_ON     = 4'd4,
    KIND_UL_OFF    = 4'd5,
    KIND_SO_ON     = 4'd6,
    KIND_SO_OFF    = 4'd7,
    KIND_FG        = 4'd8,
    KIND_BG        = 4'd9
  } kind_e;

  // one result slot leaving the front part
  typedef struct packed {
    logic        vld;
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [15:0] colour;
  } cmd_t;

  // what the front hands the back per input item
  typedef struct packed {
    cmd_t a;
    cmd_t b;
  } job_t;

endpackage

### sv/aef_front.sv
`timescale 1ns / 1ps
module aef_front #(
  parameter int unsigned CodeBits = aef_pkg::CodeBitsDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           take_i,
  input  logic [7:0]     in_byte_i,
  input  logic           suppress_i,
  output aef_pkg::job_t  job_o,
  output logic           has_job_o
);

  typedef enum logic [9:0] {
    S_TEXT     = 10'b0000000001,
    S_UTF2     = 10'b0000000010,
    S_UTF3     = 10'b0000000100,
    S_UTF4     = 10'b0000001000,
    S_ESC      = 10'b0000010000,
    S_SKIP1    = 10'b0000100000,
    S_STR      = 10'b0001000000,
    S_STR_ESC  = 10'b0010000000,
    S_CSI      = 10'b0100000000,
    S_CSI_SKIP = 10'b1000000000
  } state_e;

  localparam logic [CodeBits-1:0] CodeMax = '1;

  state_e              state_q, state_d;
  logic [2:0]          cnt_q, cnt_d;
  logic [CodeBits-1:0] cur_q, cur_d;
  logic                empty_q, empty_d;
  logic [CodeBits-1:0] pv_q [3];
  logic [2:0]          pok_q;
  logic                push_en;
  logic [CodeBits-1:0] push_v;
  logic                push_ok;

  // fully pushed view used at the terminator
  logic [CodeBits-1:0] p0, p1, p2;
  logic                k0, k1, k2;
  logic [2:0]          n_fin;

  logic [CodeBits+3:0] mul10;
  logic [CodeBits+4:0] acc;
  logic                final_b;
  logic                two_start;
  aef_pkg::job_t       job;
  aef_pkg::cmd_t       c0, c1;

  function automatic aef_pkg::cmd_t mk(input logic [3:0] k, input logic [15:0] col);
    aef_pkg::cmd_t r;
    r.vld = 1'b1; r.kind = k; r.data = 8'd0; r.colour = col;
    return r;
  endfunction

  // basic colour lookup: hit, kind and index
  function automatic logic [20:0] basic(input logic [CodeBits-1:0] c);
    logic [20:0] r;
    r = '0;
    if (c >= 30 && c <= 37) r = {1'b1, aef_pkg::KIND_FG, 16'(c - 30)};
    else if (c >= 40 && c <= 47) r = {1'b1, aef_pkg::KIND_BG, 16'(c - 40)};
    else if (c >= 90 && c <= 97) r = {1'b1, aef_pkg::KIND_FG, 16'(c - 82)};
    else if (c >= 100 && c <= 107) r = {1'b1, aef_pkg::KIND_BG, 16'(c - 92)};
    return r;
  endfunction

  logic [20:0] bc0, bc1;

  always_comb begin
    mul10 = {1'b0, cur_q, 3'b000} + {3'b000, cur_q, 1'b0};
    acc = {1'b0, mul10} + (CodeBits+5)'(in_byte_i - 8'h30);
    final_b = (in_byte_i >= 8'h40) && (in_byte_i <= 8'h7E);
    two_start = (in_byte_i == " ") || (in_byte_i == "#") || (in_byte_i == "%") ||
                (in_byte_i == "(") || (in_byte_i == ")") || (in_byte_i == "*") ||
                (in_byte_i == "+") || (in_byte_i == "-") || (in_byte_i == ".") ||
                (in_byte_i == "/");
  end

  // parameters including the trailing one closed by 'm'
  always_comb begin
    p0 = pv_q[0]; p1 = pv_q[1]; p2 = pv_q[2];
    k0 = pok_q[0]; k1 = pok_q[1]; k2 = pok_q[2];
    n_fin = cnt_q;
    if (!empty_q) begin
      unique case (cnt_q)
        3'd0: begin p0 = cur_q; k0 = 1'b1; end
        3'd1: begin p1 = cur_q; k1 = 1'b1; end
        3'd2: begin p2 = cur_q; k2 = 1'b1; end
        default: ;
      endcase
      if (cnt_q < 3'd4) n_fin = cnt_q + 3'd1;
    end
    bc0 = basic(p0);
    bc1 = basic(p1);
  end

  // sgr decode
  always_comb begin
    c0 = '0;
    c1 = '0;
    if (n_fin == 3'd0) begin
      c0 = mk(aef_pkg::KIND_RESET, 16'd0);
    end else if (n_fin == 3'd1 && k0) begin
      priority if (p0 == 0) c0 = mk(aef_pkg::KIND_RESET, 16'd0);
      else if (p0 == 1) c0 = mk(aef_pkg::KIND_BOLD, 16'd0);
      else if (p0 == 2) c0 = mk(aef_pkg::KIND_FAINT, 16'd0);
      else if (p0 == 4 || p0 == 21) c0 = mk(aef_pkg::KIND_UL_ON, 16'd0);
      else if (p0 == 7) c0 = mk(aef_pkg::KIND_SO_ON, 16'd0);
      else if (p0 == 24) c0 = mk(aef_pkg::KIND_UL_OFF, 16'd0);
      else if (p0 == 27) c0 = mk(aef_pkg::KIND_SO_OFF, 16'd0);
      else if (bc0[20]) c0 = mk(bc0[19:16], bc0[15:0]);
    end else if (n_fin == 3'd2 && k0 && k1 && p0 == 1) begin
      if (bc1[20]) begin
        c0 = mk(aef_pkg::KIND_BOLD, 16'd0);
        c1 = mk(bc1[19:16], bc1[15:0]);
      end
    end else if (n_fin == 3'd3 && k0 && k1 && k2 && p1 == 5) begin
      if (p0 == 38) c0 = mk(aef_pkg::KIND_FG, 16'(p2));
      else if (p0 == 48) c0 = mk(aef_pkg::KIND_BG, 16'(p2));
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cur_d = cur_q;
    empty_d = empty_q;
    push_en = 1'b0;
    push_v = cur_q;
    push_ok = ~empty_q;
    job = '0;
    unique case (state_q)
      S_TEXT: begin
        if (in_byte_i == 8'h1B) state_d = S_ESC;
        else if (in_byte_i == 8'h0C || in_byte_i == 8'h0B) begin
          job.a = mk(aef_pkg::KIND_BYTE, 16'd0);
          job.a.data = 8'h0A;
        end else if (in_byte_i == 8'h0D || in_byte_i == 8'h07 || in_byte_i == 8'h08 ||
                     in_byte_i == 8'h05 || in_byte_i == 8'h0F || in_byte_i == 8'h0E) begin
          state_d = S_TEXT;
        end else begin
          if ((in_byte_i & 8'hE0) == 8'hC0) state_d = S_UTF2;
          else if ((in_byte_i & 8'hF0) == 8'hE0) state_d = S_UTF3;
          else if ((in_byte_i & 8'hF8) == 8'hF0) state_d = S_UTF4;
          job.a = mk(aef_pkg::KIND_BYTE, 16'd0);
          job.a.data = in_byte_i;
        end
      end
      S_UTF2, S_UTF3, S_UTF4: begin
        state_d = (state_q == S_UTF4) ? S_UTF3 : (state_q == S_UTF3) ? S_UTF2 : S_TEXT;
        job.a = mk(aef_pkg::KIND_BYTE, 16'd0);
        job.a.data = in_byte_i;
      end
      S_ESC: begin
        if (in_byte_i == "[") begin
          cnt_d = 3'd0; cur_d = '0; empty_d = 1'b1; state_d = S_CSI;
        end else if (in_byte_i == "]" || in_byte_i == "_" || in_byte_i == "P" ||
                     in_byte_i == "^") state_d = S_STR;
        else if (two_start) state_d = S_SKIP1;
        else state_d = S_TEXT;
      end
      S_SKIP1: state_d = S_TEXT;
      S_STR: begin
        if (in_byte_i == 8'h07) state_d = S_TEXT;
        else if (in_byte_i == 8'h1B) state_d = S_STR_ESC;
      end
      S_STR_ESC: state_d = (in_byte_i == "\\") ? S_TEXT : S_STR;
      S_CSI_SKIP: if (final_b) state_d = S_TEXT;
      S_CSI: begin
        if (in_byte_i == ";") begin
          push_en = 1'b1;
          if (cnt_q < 3'd4) cnt_d = cnt_q + 3'd1;
          cur_d = '0; empty_d = 1'b1;
        end else if (in_byte_i == "m") begin
          if (!suppress_i) begin
            job.a = c0;
            job.b = c1;
          end
          cnt_d = 3'd0; cur_d = '0; empty_d = 1'b1; state_d = S_TEXT;
        end else if (final_b) begin
          cnt_d = 3'd0; cur_d = '0; empty_d = 1'b1; state_d = S_TEXT;
        end else if (in_byte_i >= "0" && in_byte_i <= "9") begin
          // saturating decimal accumulate
          cur_d = (acc > (CodeBits+5)'(CodeMax)) ? CodeMax : acc[CodeBits-1:0];
          empty_d = 1'b0;
        end else begin
          cnt_d = 3'd0; cur_d = '0; empty_d = 1'b1; state_d = S_CSI_SKIP;
        end
      end
      default: state_d = S_TEXT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_TEXT;
      cnt_q <= 3'd0;
      cur_q <= '0;
      empty_q <= 1'b1;
    end else if (take_i) begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && push_en && cnt_q < 3'd3) begin
      pv_q[cnt_q[1:0]] <= push_v;
      pok_q[cnt_q[1:0]] <= push_ok;
    end
  end

  assign job_o = job;
  assign has_job_o = job.a.vld;

endmodule

### sv/aef_back.sv
`timescale 1ns / 1ps
`include "ansi_escape_filter_core_macros.svh"
module aef_back #(
  parameter int unsigned Depth = aef_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  aef_pkg::job_t job_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [3:0]    kind_o,
  output logic [7:0]    out_byte_o,
  output logic [15:0]   colour_index_o,
  output logic          last_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  aef_pkg::job_t    mem_q [Depth];
  logic [Aw-1:0]    wp_q, rp_q;
  logic [Aw:0]      cnt_q;
  logic             half_q;
  logic             rd;
  aef_pkg::cmd_t    cur;

  assign empty_o = (cnt_q == '0);
  assign full_o = (cnt_q == (Aw+1)'(Depth));
  assign cur = half_q ? mem_q[rp_q].b : mem_q[rp_q].a;
  assign kind_o = cur.kind;
  assign out_byte_o = cur.data;
  assign colour_index_o = cur.colour;
  assign last_o = half_q | ~mem_q[rp_q].b.vld;
  // an entry leaves once its last command is taken
  assign rd = pop_i & ~empty_o & last_o;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
      half_q <= 1'b0;
    end else begin
      if (wr_i) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr_i) - (Aw+1)'(rd);
      if (pop_i && !empty_o) half_q <= ~last_o;
    end
  end

  `AEF_NEVER(a_no_overflow, wr_i && full_o, "write into full queue")
  `AEF_NEVER(a_half_needs_item, half_q && empty_o, "second command with no entry")
  `AEF_ASSERT(a_count_step, rd && !wr_i |=> cnt_q == $past(cnt_q) - 1'b1, "count slip")

endmodule

### sv/ansi_escape_filter_core.sv
// a taken byte's result is written into the result queue, whose outputs show its head entry
// throughput: one byte per cycle while the queue is not full; a byte yielding two commands holds its entry two pops
// the front parser and a 4-entry result queue decouple input and output stalls
// reset: asynchronous active-low, parser to text state, queue empty, styling enabled
`timescale 1ns / 1ps
`include "ansi_escape_filter_core_macros.svh"
module ansi_escape_filter_core #(
  parameter int unsigned CodeBits = aef_pkg::CodeBitsDefault,
  parameter int unsigned Depth = aef_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic [15:0] colour_index_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic          suppress_q;
  logic          take;
  logic          has_job;
  logic          q_full;
  aef_pkg::job_t job;

  assign full = q_full;
  assign take = push & ~q_full;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) suppress_q <= 1'b0;
    else if (cfg_valid_i) suppress_q <= cfg_data_i;
  end

  aef_front #(.CodeBits(CodeBits)) u_front (
    .clk_i, .rst_ni, .take_i(take), .in_byte_i, .suppress_i(suppress_q),
    .job_o(job), .has_job_o(has_job)
  );

  aef_back #(.Depth(Depth)) u_back (
    .clk_i, .rst_ni, .wr_i(take & has_job), .job_i(job), .full_o(q_full),
    .empty_o(empty), .pop_i(pop), .kind_o, .out_byte_o, .colour_index_o, .last_o
  );

  `AEF_NEVER(a_bytes_clean, !empty && kind_o != aef_pkg::KIND_BYTE && out_byte_o != 8'd0,
    "command carries byte")
  `AEF_ASSERT(a_full_blocks, full |-> !take, "item taken while full")
  `AEF_NEVER(a_kind_range, !empty && kind_o > aef_pkg::KIND_BG, "bad kind")

endmodule

### bench/ansi_escape_filter_core_checker.sv
`timescale 1ns / 1ps
module ansi_escape_filter_core_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [3:0]  kind_o,
  input  logic [7:0]  out_byte_o,
  input  logic [15:0] colour_index_o,
  input  logic        last_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic        cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [3:0] {
    ST_TEXT, ST_UTF2, ST_UTF3, ST_UTF4, ST_ESC, ST_SKIP1,
    ST_STR, ST_STR_ESC, ST_CSI, ST_CSI_SKIP
  } parse_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  data;
    logic [15:0] colour;
    logic        last;
  } exp_t;

  localparam logic [16:0] CodeMax = 17'hFFFF;

  exp_t        cmd_q[$];
  parse_e      pstate;
  logic        quiet;
  int unsigned nparams;
  logic [16:0] pval[3];
  logic        pok[3];
  logic [16:0] cur;
  logic        cur_empty;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = cmd_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fails++;
  endtask

  function automatic exp_t mk(input aef_pkg::kind_e k, input logic [7:0] d,
                              input logic [15:0] c);
    exp_t r;
    r.kind = k; r.data = d; r.colour = c; r.last = 1'b0;
    return r;
  endfunction

  task automatic add_param(input logic [16:0] v, input logic ok);
    if (nparams < 3) begin
      pval[nparams] = v;
      pok[nparams] = ok;
    end
    if (nparams < 4) nparams++;
  endtask

  // basic colour lookup; returns 0 when not a colour code
  function automatic bit colour_of(input logic [16:0] c, output exp_t r);
    r = '0;
    if (c >= 30 && c <= 37) r = mk(aef_pkg::KIND_FG, 8'd0, 16'(c - 30));
    else if (c >= 40 && c <= 47) r = mk(aef_pkg::KIND_BG, 8'd0, 16'(c - 40));
    else if (c >= 90 && c <= 97) r = mk(aef_pkg::KIND_FG, 8'd0, 16'(c - 82));
    else if (c >= 100 && c <= 107) r = mk(aef_pkg::KIND_BG, 8'd0, 16'(c - 92));
    else return 0;
    return 1;
  endfunction

  task automatic style_cmds(inout exp_t out[$]);
    exp_t r;
    if (nparams == 0) out = {out, mk(aef_pkg::KIND_RESET, 8'd0, 16'd0)};
    else if (nparams == 1 && pok[0]) begin
      case (pval[0])
        0: out = {out, mk(aef_pkg::KIND_RESET, 8'd0, 16'd0)};
        1: out = {out, mk(aef_pkg::KIND_BOLD, 8'd0, 16'd0)};
        2: out = {out, mk(aef_pkg::KIND_FAINT, 8'd0, 16'd0)};
        4, 21: out = {out, mk(aef_pkg::KIND_UL_ON, 8'd0, 16'd0)};
        7: out = {out, mk(aef_pkg::KIND_SO_ON, 8'd0, 16'd0)};
        24: out = {out, mk(aef_pkg::KIND_UL_OFF, 8'd0, 16'd0)};
        27: out = {out, mk(aef_pkg::KIND_SO_OFF, 8'd0, 16'd0)};
        default: if (colour_of(pval[0], r)) out = {out, r};
      endcase
    end else if (nparams == 2 && pok[0] && pok[1] && pval[0] == 1) begin
      if (colour_of(pval[1], r)) begin
        out = {out, mk(aef_pkg::KIND_BOLD, 8'd0, 16'd0)};
        out = {out, r};
      end
    end else if (nparams == 3 && pok[0] && pok[1] && pok[2] && pval[1] == 5) begin
      if (pval[0] == 38) out = {out, mk(aef_pkg::KIND_FG, 8'd0, pval[2][15:0])};
      else if (pval[0] == 48) out = {out, mk(aef_pkg::KIND_BG, 8'd0, pval[2][15:0])};
    end
  endtask

  task automatic take_byte(input logic [7:0] c);
    exp_t out[$];
    logic [20:0] v;
    case (pstate)
      ST_TEXT: begin
        if (c == 8'h1B) pstate = ST_ESC;
        else if (c == 8'h0C || c == 8'h0B)
          out = {out, mk(aef_pkg::KIND_BYTE, 8'h0A, 16'd0)};
        else if (!(c inside {8'h0D, 8'h07, 8'h08, 8'h05, 8'h0F, 8'h0E})) begin
          if ((c & 8'hE0) == 8'hC0) pstate = ST_UTF2;
          else if ((c & 8'hF0) == 8'hE0) pstate = ST_UTF3;
          else if ((c & 8'hF8) == 8'hF0) pstate = ST_UTF4;
          out = {out, mk(aef_pkg::KIND_BYTE, c, 16'd0)};
        end
      end
      ST_UTF2: begin pstate = ST_TEXT; out = {out, mk(aef_pkg::KIND_BYTE, c, 16'd0)}; end
      ST_UTF3: begin pstate = ST_UTF2; out = {out, mk(aef_pkg::KIND_BYTE, c, 16'd0)}; end
      ST_UTF4: begin pstate = ST_UTF3; out = {out, mk(aef_pkg::KIND_BYTE, c, 16'd0)}; end
      ST_ESC: begin
        if (c == "[") begin
          nparams = 0; cur = 0; cur_empty = 1; pstate = ST_CSI;
        end else if (c inside {"]", "_", "P", "^"}) pstate = ST_STR;
        else if (c inside {" ", "#", "%", "(", ")", "*", "+", "-", ".", "/"})
          pstate = ST_SKIP1;
        else pstate = ST_TEXT;
      end
      ST_SKIP1: pstate = ST_TEXT;
      ST_STR: begin
        if (c == 8'h07) pstate = ST_TEXT;
        else if (c == 8'h1B) pstate = ST_STR_ESC;
      end
      ST_STR_ESC: pstate = (c == "\\") ? ST_TEXT : ST_STR;
      ST_CSI_SKIP: if (c >= 8'h40 && c <= 8'h7E) pstate = ST_TEXT;
      ST_CSI: begin
        if (c == ";") begin
          add_param(cur, !cur_empty);
          cur = 0; cur_empty = 1;
        end else if (c == "m") begin
          if (!cur_empty) add_param(cur, 1'b1);
          if (!quiet) style_cmds(out);
          nparams = 0; cur = 0; cur_empty = 1; pstate = ST_TEXT;
        end else if (c >= 8'h40 && c <= 8'h7E) begin
          nparams = 0; cur = 0; cur_empty = 1; pstate = ST_TEXT;
        end else if (c >= "0" && c <= "9") begin
          v = {4'd0, cur} * 21'd10 + {13'd0, c - 8'h30};
          cur = (v > {4'd0, CodeMax}) ? CodeMax : v[16:0];
          cur_empty = 0;
        end else begin
          nparams = 0; cur = 0; cur_empty = 1; pstate = ST_CSI_SKIP;
        end
      end
      default: pstate = ST_TEXT;
    endcase
    if (out.size() > 0) out[out.size() - 1].last = 1'b1;
    foreach (out[i]) cmd_q = {cmd_q, out[i]};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exp_t w;
    if (!rst_ni) begin
      pstate = ST_TEXT;
      quiet = 1'b0;
      nparams = 0; cur = 0; cur_empty = 1;
      for (int i = 0; i < 3; i++) begin pval[i] = 0; pok[i] = 0; end
      cmd_q.delete();
      fails = 0;
    end else begin
      if (pop && !empty) begin
        if (cmd_q.size() == 0) report("unexpected item", 32'(kind_o), 32'd0);
        else begin
          w = cmd_q.pop_front();
          if (kind_o !== w.kind) report("kind", 32'(kind_o), 32'(w.kind));
          if (out_byte_o !== w.data) report("out_byte", 32'(out_byte_o), 32'(w.data));
          if (colour_index_o !== w.colour)
            report("colour_index", 32'(colour_index_o), 32'(w.colour));
          if (last_o !== w.last) report("last", 32'(last_o), 32'(w.last));
        end
      end
      if (push && !full) take_byte(in_byte_i);
      if (cfg_valid_i && cfg_ready_o) quiet = cfg_data_i;
    end
  end
endmodule

### bench/ansi_escape_filter_core_tb.sv
`timescale 1ns / 1ps
module ansi_escape_filter_core_tb;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_byte_i = 8'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic [15:0] colour_index_o;
  logic        last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  int          fail_count;
  int          pending;
  bit          draining = 0;

  always #5 clk_i = ~clk_i;

  ansi_escape_filter_core i_dut (.*);

  ansi_escape_filter_core_checker i_chk (
    .clk_i, .rst_ni, .push, .full, .in_byte_i, .empty, .pop, .kind_o, .out_byte_o,
    .colour_index_o, .last_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // push stays high across back-to-back items
  task automatic send(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send(s[i]);
  endtask

  task automatic write_cfg(input logic v);
    push <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_number();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) send_str($sformatf("%0d", $urandom_range(0, 999999)));
    else if (r < 4) send_str($sformatf("%0d", $urandom_range(0, 9)));
    else if (r < 7) send_str($sformatf("%0d", $urandom_range(20, 49)));
    else if (r < 9) send_str($sformatf("%0d", $urandom_range(90, 107)));
    else send_str($sformatf("%0d", $urandom_range(0, 300)));
  endtask

  task automatic random_chunk();
    int r, n;
    r = $urandom_range(0, 15);
    case (r)
      0, 1, 2, 3: send(8'($urandom_range(0, 255)));
      4, 5, 6, 7: begin
        send(8'h1B); send("[");
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) != 0) send_number();
          if (i < n - 1) send(";");
        end
        if ($urandom_range(0, 5) == 0) send(8'($urandom_range(0, 255)));
        send("m");
      end
      8: begin send(8'h1B); send("["); send_str("38;5;"); send_number(); send("m"); end
      9: begin send(8'h1B); send("["); send_str("48;5;"); send_number(); send("m"); end
      10: begin send(8'h1B); send("["); send_str("1;"); send_number(); send("m"); end
      11: begin
        send(8'h1B); send("]"); send(8'($urandom_range(32, 126)));
        if ($urandom_range(0, 1)) begin send(8'h1B); send("x"); end
        if ($urandom_range(0, 1)) send(8'h07); else begin send(8'h1B); send("\\"); end
      end
      12: begin send(8'h1B); send("("); send(8'($urandom_range(0, 255))); end
      13: begin
        send(8'($urandom_range(8'hC0, 8'hFF))); send(8'h1B); send(8'h80); send(8'h80);
      end
      14: begin
        send(8'h1B); send(8'($urandom_range(0, 255))); send(8'($urandom_range(0, 255)));
      end
      default: begin send(8'h1B); send("["); send_str("2;3"); send("H"); end
    endcase
  endtask

  initial begin
    int wait_cnt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send(8'h00); send(8'hFF); send("A"); send(8'h0C); send(8'h0B); send(8'h0D);
    send(8'h07); send(8'h08); send(8'h05); send(8'h0E); send(8'h0F);
    send_str("\033[m\033[1;31m\033[1;102m\033[38;5;200m\033[48;5;99999m");
    send_str("\033[;1m\033[1;2;3;4m\033[999999m\033[7m\033[27;m\033[2J");
    send_str("\033[1?x@\033]t\033q\033\\\033P\007\033#88\033_a\007\033^a\007");
    send(8'hE2); send(8'h1B); send(8'h1B);
    write_cfg(1'b1);
    send_str("\033[1;31m\033[0mZ");
    write_cfg(1'b0);
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 55; i++) random_chunk();
      write_cfg(ph % 2 == 0);
    end
    write_cfg(1'b0);
    draining = 1;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 100000) begin @(posedge clk_i); wait_cnt++; end
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("ansi_escape_filter_core_tb OK");
    else $display("ansi_escape_filter_core_tb NOT OK");
    $finish;
  end

  // receiver stalls drawn per item
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 13);
      if ($urandom_range(0, 3) == 0 || draining) gap = 0;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
    end
  end

  initial begin
    #20ms;
    $display("ansi_escape_filter_core_tb NOT OK");
    $finish;
  end
endmodule

### filelist.f
+incdir+sv
sv/aef_pkg.sv
sv/aef_front.sv
sv/aef_back.sv
sv/ansi_escape_filter_core.sv
bench/ansi_escape_filter_core_checker.sv
bench/ansi_escape_filter_core_tb.sv
